// ----- hw/rtl/lsb_first_field_bit_packer_macros.svh -----
// Assertion macros for the LSB-first field bit packer.
`ifndef LSB_FIRST_FIELD_BIT_PACKER_MACROS_SVH
`define LSB_FIRST_FIELD_BIT_PACKER_MACROS_SVH

// Clocked property check, disabled during reset.
`define LFBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define LFBP_ASSERT_NEVER(lbl, expr, msg) \
  `LFBP_ASSERT(lbl, !(expr), msg)

`endif

// ----- hw/rtl/lfbp_pkg.sv -----
// Types and constants shared by the LSB-first field bit packer modules.
`timescale 1ns / 1ps

package lfbp_pkg;

  localparam int unsigned CFG_IDX_W     = 8;
  localparam int unsigned ACC_W         = 63;
  localparam int unsigned CNT_W         = 6;
  localparam int unsigned CHUNK_W       = 56;
  localparam int unsigned SREG_W        = 52;
  localparam int unsigned RAW_MAX_BITS  = 56;
  localparam int unsigned U64_SMALL_LIM = 17;
  localparam int unsigned U64_MID_LIM   = 273;
  localparam int unsigned U64_LAST_STEP = 6;   // continuation at shift 60

  localparam logic [CFG_IDX_W-1:0] CFG_PRELOAD_BITS  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRELOAD_COUNT = 8'd1;

  typedef enum logic [1:0] {
    REQ_RAW = 2'd0,
    REQ_PAD = 2'd1,
    REQ_U32 = 2'd2,
    REQ_U64 = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPEND,
    ST_U32,
    ST_U64_HEAD,
    ST_U64_CONT,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef enum logic [2:0] {
    UOP_RAW,
    UOP_PAD,
    UOP_U32,
    UOP_U64_HEAD,
    UOP_U64_CONT
  } uop_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] value;
    logic [5:0]  bit_count;
    logic [31:0] offset_0;
    logic [31:0] offset_1;
    logic [31:0] offset_2;
    logic [31:0] offset_3;
    logic [4:0]  width_0;
    logic [4:0]  width_1;
    logic [4:0]  width_2;
    logic [4:0]  width_3;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       status;
    logic       last;
  } out_t;

  // Chunk formed by the shared unit for one append step.
  typedef struct packed {
    logic [CHUNK_W-1:0] bits;
    logic [CNT_W-1:0]   n;
    logic               hit;
    logic               more;
  } chunk_t;

  typedef struct packed {
    logic               append;
    logic               drain;
    logic [CHUNK_W-1:0] bits;
    logic [CNT_W-1:0]   n;
  } acc_cmd_t;

  typedef struct packed {
    logic       cnt_ge8;
    logic [2:0] pend_cnt;
    logic [7:0] low_byte;
  } acc_sts_t;

  typedef struct packed {
    logic       push;
    logic       fin;
    logic       err;
    logic [7:0] data;
  } emit_t;

  typedef struct packed {
    logic ready;
    logic held;
  } ost_sts_t;

endpackage

// ----- hw/rtl/lfbp_chunk_unit.sv -----
// Shared subtract/compare unit that forms the next bit chunk of a request.
`timescale 1ns / 1ps

module lfbp_chunk_unit (
  input  lfbp_pkg::uop_e                  op_i,
  input  lfbp_pkg::in_t                   item_i,
  input  logic [1:0]                      sel_i,
  input  logic [2:0]                      pend_cnt_i,
  input  logic [lfbp_pkg::SREG_W-1:0]     sreg_i,
  input  logic [2:0]                      step_i,
  output lfbp_pkg::chunk_t                chunk_o
);

  logic [31:0]                   sub_b;
  logic [31:0]                   diff;
  logic [31:0]                   offset;
  logic [4:0]                    width;
  logic [lfbp_pkg::CHUNK_W-1:0]  raw_mask;
  logic                          lt_small;
  logic                          lt_mid;

  always_comb begin
    case (sel_i)
      2'd0:    begin offset = item_i.offset_0; width = item_i.width_0; end
      2'd1:    begin offset = item_i.offset_1; width = item_i.width_1; end
      2'd2:    begin offset = item_i.offset_2; width = item_i.width_2; end
      default: begin offset = item_i.offset_3; width = item_i.width_3; end
    endcase
  end

  assign lt_small = item_i.value < 64'(lfbp_pkg::U64_SMALL_LIM);
  assign lt_mid   = item_i.value < 64'(lfbp_pkg::U64_MID_LIM);

  // One subtractor serves the U32 search and the short U64 prefixes.
  always_comb begin
    case (op_i)
      lfbp_pkg::UOP_U32:      sub_b = offset;
      lfbp_pkg::UOP_U64_HEAD: sub_b = lt_small ? 32'd1 : 32'(lfbp_pkg::U64_SMALL_LIM);
      default:                sub_b = 32'd0;
    endcase
  end

  assign diff     = item_i.value[31:0] - sub_b;
  assign raw_mask = (56'd1 << item_i.bit_count) - 56'd1;

  always_comb begin
    chunk_o = '0;
    case (op_i)
      lfbp_pkg::UOP_RAW: begin
        chunk_o.bits = item_i.value[lfbp_pkg::CHUNK_W-1:0] & raw_mask;
        chunk_o.n    = item_i.bit_count;
        chunk_o.hit  = item_i.bit_count <= 6'(lfbp_pkg::RAW_MAX_BITS);
      end
      lfbp_pkg::UOP_PAD: begin
        chunk_o.n   = (pend_cnt_i == 3'd0) ? 6'd0 : 6'(4'd8 - {1'b0, pend_cnt_i});
        chunk_o.hit = 1'b1;
      end
      lfbp_pkg::UOP_U32: begin
        chunk_o.bits = lfbp_pkg::CHUNK_W'({diff, sel_i});
        chunk_o.n    = 6'(width) + 6'd2;
        chunk_o.hit  = (diff >> width) == 32'd0;
      end
      lfbp_pkg::UOP_U64_HEAD: begin
        chunk_o.hit = 1'b1;
        if (item_i.value == 64'd0) begin
          chunk_o.n = 6'd2;
        end else if (lt_small) begin
          chunk_o.bits = lfbp_pkg::CHUNK_W'({diff[3:0], 2'b01});
          chunk_o.n    = 6'd6;
        end else if (lt_mid) begin
          chunk_o.bits = lfbp_pkg::CHUNK_W'({diff[7:0], 2'b10});
          chunk_o.n    = 6'd10;
        end else begin
          chunk_o.bits = lfbp_pkg::CHUNK_W'({item_i.value[11:0], 2'b11});
          chunk_o.n    = 6'd14;
          chunk_o.more = 1'b1;
        end
      end
      lfbp_pkg::UOP_U64_CONT: begin
        chunk_o.hit = 1'b1;
        if (sreg_i == '0) begin
          chunk_o.n = 6'd1;
        end else if (step_i == 3'(lfbp_pkg::U64_LAST_STEP)) begin
          chunk_o.bits = lfbp_pkg::CHUNK_W'({sreg_i[3:0], 1'b1});
          chunk_o.n    = 6'd5;
        end else begin
          chunk_o.bits = lfbp_pkg::CHUNK_W'({sreg_i[7:0], 1'b1});
          chunk_o.n    = 6'd9;
          chunk_o.more = 1'b1;
        end
      end
      default: begin
        chunk_o = '0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/lfbp_bit_acc.sv -----
// Bit accumulator holding the pending bits, with preload registers.
`timescale 1ns / 1ps

module lfbp_bit_acc (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lfbp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [7:0]                        cfg_data_i,
  input  lfbp_pkg::acc_cmd_t                cmd_i,
  output lfbp_pkg::acc_sts_t                sts_o
);

  logic [7:0]                   pre_bits_q, pre_bits_d;
  logic [2:0]                   pre_cnt_q, pre_cnt_d;
  logic [lfbp_pkg::ACC_W-1:0]   acc_q, acc_d;
  logic [lfbp_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [7:0]                   pre_mask;

  always_comb begin
    pre_bits_d = pre_bits_q;
    pre_cnt_d  = pre_cnt_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        lfbp_pkg::CFG_PRELOAD_BITS:  pre_bits_d = cfg_data_i;
        lfbp_pkg::CFG_PRELOAD_COUNT: pre_cnt_d  = cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  assign pre_mask = (8'd1 << pre_cnt_d) - 8'd1;

  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    if (cfg_we_i && (cfg_index_i == lfbp_pkg::CFG_PRELOAD_BITS ||
                     cfg_index_i == lfbp_pkg::CFG_PRELOAD_COUNT)) begin
      // reload pending bits from both registers, drop bits above the count
      acc_d = lfbp_pkg::ACC_W'(pre_bits_d[6:0] & pre_mask[6:0]);
      cnt_d = lfbp_pkg::CNT_W'(pre_cnt_d);
    end else if (cmd_i.append) begin
      acc_d = acc_q | (lfbp_pkg::ACC_W'(cmd_i.bits) << cnt_q[2:0]);
      cnt_d = cnt_q + cmd_i.n;
    end else if (cmd_i.drain) begin
      acc_d = acc_q >> 8;
      cnt_d = cnt_q - 6'd8;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_bits_q <= '0;
      pre_cnt_q  <= '0;
      acc_q      <= '0;
      cnt_q      <= '0;
    end else begin
      pre_bits_q <= pre_bits_d;
      pre_cnt_q  <= pre_cnt_d;
      acc_q      <= acc_d;
      cnt_q      <= cnt_d;
    end
  end

  assign sts_o.cnt_ge8  = cnt_q[5:3] != 3'd0;
  assign sts_o.pend_cnt = cnt_q[2:0];
  assign sts_o.low_byte = acc_q[7:0];

endmodule

// ----- hw/rtl/lfbp_out_stage.sv -----
// Output stage: holds back one byte so the last result of an item can be marked.
`timescale 1ns / 1ps

module lfbp_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lfbp_pkg::emit_t    emit_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output lfbp_pkg::out_t     out_data_o,
  output lfbp_pkg::ost_sts_t sts_o
);

  logic            vld_q, vld_d;
  logic            held_q, held_d;
  logic [7:0]      hb_q, hb_d;
  lfbp_pkg::out_t  data_q, data_d;

  always_comb begin
    vld_d  = vld_q && out_stall_i;
    held_d = held_q;
    hb_d   = hb_q;
    data_d = data_q;
    if (emit_i.push) begin
      hb_d   = emit_i.data;
      held_d = 1'b1;
      if (held_q) begin
        data_d = '{out_byte: hb_q, byte_valid: 1'b1, status: 1'b0, last: 1'b0};
        vld_d  = 1'b1;
      end
    end else if (emit_i.fin) begin
      // close the word: held byte as last, or an empty result
      if (held_q) begin
        data_d = '{out_byte: hb_q, byte_valid: 1'b1, status: emit_i.err, last: 1'b1};
      end else begin
        data_d = '{out_byte: 8'd0, byte_valid: 1'b0, status: emit_i.err, last: 1'b1};
      end
      vld_d  = 1'b1;
      held_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      held_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hb_q   <= hb_d;
    data_q <= data_d;
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = data_q;
  assign sts_o.ready = !vld_q || !out_stall_i;
  assign sts_o.held  = held_q;

endmodule

// ----- hw/rtl/lfbp_ctrl.sv -----
// Sequencer that steps a request through the shared chunk unit and the accumulator.
`timescale 1ns / 1ps

module lfbp_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  lfbp_pkg::in_t                 in_data_i,
  output logic                          idle_o,
  output lfbp_pkg::uop_e                uop_o,
  output lfbp_pkg::in_t                 item_o,
  output logic [1:0]                    sel_o,
  output logic [lfbp_pkg::SREG_W-1:0]   sreg_o,
  output logic [2:0]                    step_o,
  input  lfbp_pkg::chunk_t              chunk_i,
  input  lfbp_pkg::acc_sts_t            acc_sts_i,
  input  lfbp_pkg::ost_sts_t            ost_sts_i,
  output lfbp_pkg::acc_cmd_t            acc_cmd_o,
  output lfbp_pkg::emit_t               emit_o
);

  lfbp_pkg::state_e              state_q, state_d;
  lfbp_pkg::in_t                 item_q, item_d;
  logic [1:0]                    sel_q, sel_d;
  logic [lfbp_pkg::SREG_W-1:0]   sreg_q, sreg_d;
  logic [2:0]                    step_q, step_d;
  logic                          more_q, more_d;
  logic                          err_q, err_d;
  logic                          accept;

  assign accept = (state_q == lfbp_pkg::ST_IDLE) && in_valid_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lfbp_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (lfbp_pkg::req_e'(in_data_i.req_type))
            lfbp_pkg::REQ_U32: state_d = lfbp_pkg::ST_U32;
            lfbp_pkg::REQ_U64: state_d = lfbp_pkg::ST_U64_HEAD;
            default:           state_d = lfbp_pkg::ST_APPEND;
          endcase
        end
      end
      lfbp_pkg::ST_APPEND: begin
        state_d = chunk_i.hit ? lfbp_pkg::ST_DRAIN : lfbp_pkg::ST_FINISH;
      end
      lfbp_pkg::ST_U32: begin
        if (chunk_i.hit) begin
          state_d = lfbp_pkg::ST_DRAIN;
        end else if (sel_q == 2'd3) begin
          state_d = lfbp_pkg::ST_FINISH;
        end
      end
      lfbp_pkg::ST_U64_HEAD: state_d = lfbp_pkg::ST_DRAIN;
      lfbp_pkg::ST_U64_CONT: state_d = lfbp_pkg::ST_DRAIN;
      lfbp_pkg::ST_DRAIN: begin
        if (!acc_sts_i.cnt_ge8) begin
          state_d = more_q ? lfbp_pkg::ST_U64_CONT : lfbp_pkg::ST_FINISH;
        end
      end
      lfbp_pkg::ST_FINISH: begin
        if (ost_sts_i.ready) begin
          state_d = lfbp_pkg::ST_IDLE;
        end
      end
      default: state_d = lfbp_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    idle_o     = state_q == lfbp_pkg::ST_IDLE;
    in_stall_o = state_q != lfbp_pkg::ST_IDLE;
    case (state_q)
      lfbp_pkg::ST_APPEND: begin
        uop_o = (lfbp_pkg::req_e'(item_q.req_type) == lfbp_pkg::REQ_PAD) ?
                lfbp_pkg::UOP_PAD : lfbp_pkg::UOP_RAW;
      end
      lfbp_pkg::ST_U32:      uop_o = lfbp_pkg::UOP_U32;
      lfbp_pkg::ST_U64_HEAD: uop_o = lfbp_pkg::UOP_U64_HEAD;
      lfbp_pkg::ST_U64_CONT: uop_o = lfbp_pkg::UOP_U64_CONT;
      default:               uop_o = lfbp_pkg::UOP_RAW;
    endcase

    acc_cmd_o.append = (((state_q == lfbp_pkg::ST_APPEND) ||
                         (state_q == lfbp_pkg::ST_U32)) && chunk_i.hit) ||
                       (state_q == lfbp_pkg::ST_U64_HEAD) ||
                       (state_q == lfbp_pkg::ST_U64_CONT);
    acc_cmd_o.drain  = (state_q == lfbp_pkg::ST_DRAIN) && acc_sts_i.cnt_ge8 &&
                       ost_sts_i.ready;
    acc_cmd_o.bits   = chunk_i.bits;
    acc_cmd_o.n      = chunk_i.n;

    emit_o.push = acc_cmd_o.drain;
    emit_o.fin  = (state_q == lfbp_pkg::ST_FINISH) && ost_sts_i.ready;
    emit_o.err  = err_q;
    emit_o.data = acc_sts_i.low_byte;
  end

  // item and iteration registers
  always_comb begin
    item_d = item_q;
    sel_d  = sel_q;
    sreg_d = sreg_q;
    step_d = step_q;
    more_d = more_q;
    err_d  = err_q;
    case (state_q)
      lfbp_pkg::ST_IDLE: begin
        if (accept) begin
          item_d = in_data_i;
          sel_d  = 2'd0;
          more_d = 1'b0;
          err_d  = 1'b0;
        end
      end
      lfbp_pkg::ST_APPEND: begin
        if (!chunk_i.hit) begin
          err_d = 1'b1;
        end
      end
      lfbp_pkg::ST_U32: begin
        if (!chunk_i.hit) begin
          sel_d = sel_q + 2'd1;
          if (sel_q == 2'd3) begin
            err_d = 1'b1;
          end
        end
      end
      lfbp_pkg::ST_U64_HEAD: begin
        more_d = chunk_i.more;
        sreg_d = item_q.value[63:12];
        step_d = 3'd0;
      end
      lfbp_pkg::ST_U64_CONT: begin
        more_d = chunk_i.more;
        sreg_d = sreg_q >> 8;
        step_d = step_q + 3'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lfbp_pkg::ST_IDLE;
      sel_q   <= '0;
      step_q  <= '0;
      more_q  <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      step_q  <= step_d;
      more_q  <= more_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    sreg_q <= sreg_d;
  end

  assign item_o = item_q;
  assign sel_o  = sel_q;
  assign sreg_o = sreg_q;
  assign step_o = step_q;

endmodule

// ----- hw/rtl/lsb_first_field_bit_packer.sv -----
// LSB-first field bit packer: raw, zero pad, U32 and U64 header fields into bytes.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one request per word.
// The block takes one request at a time and stalls the input until every
// result word of the current request has been handed to the output register.
// Output channel (out_valid_o / out_stall_i / out_data_o): one word per finished
// byte in stream order, or a single empty word when a request finishes no byte;
// the last word of a request has last set, and status is set on a rejected one.
// Each request is stepped as chunks: raw or pad one chunk, U32 one per distribution
// tried, U64 a head chunk and then continuation chunks, with complete bytes drained
// after each appended chunk; a rejected request goes straight to its finishing word.
// The sequencer passes one chunk per cycle through the shared subtract/compare unit
// and drains one byte per cycle from the accumulator unless the output stalls.
// One byte is held back so that last can be marked; an output stall holds the
// sequencer at its next byte or finishing word.
// Reset clears the preload registers and the pending bits. Configuration
// writes (cfg_valid_i / cfg_ready_o) are taken while idle, and a write to either
// preload register reloads the pending bits from both preload registers.
`timescale 1ns / 1ps
`include "lsb_first_field_bit_packer_macros.svh"

module lsb_first_field_bit_packer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  lfbp_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output lfbp_pkg::out_t                 out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lfbp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                     cfg_data_i
);

  logic                          ctrl_idle;
  lfbp_pkg::uop_e                uop;
  lfbp_pkg::in_t                 item;
  logic [1:0]                    sel;
  logic [lfbp_pkg::SREG_W-1:0]   sreg;
  logic [2:0]                    step;
  lfbp_pkg::chunk_t              chunk;
  lfbp_pkg::acc_sts_t            acc_sts;
  lfbp_pkg::acc_cmd_t            acc_cmd;
  lfbp_pkg::ost_sts_t            ost_sts;
  lfbp_pkg::emit_t               emit;

  assign cfg_ready_o = ctrl_idle;

  lfbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .idle_o     (ctrl_idle),
    .uop_o      (uop),
    .item_o     (item),
    .sel_o      (sel),
    .sreg_o     (sreg),
    .step_o     (step),
    .chunk_i    (chunk),
    .acc_sts_i  (acc_sts),
    .ost_sts_i  (ost_sts),
    .acc_cmd_o  (acc_cmd),
    .emit_o     (emit)
  );

  lfbp_chunk_unit u_chunk (
    .op_i       (uop),
    .item_i     (item),
    .sel_i      (sel),
    .pend_cnt_i (acc_sts.pend_cnt),
    .sreg_i     (sreg),
    .step_i     (step),
    .chunk_o    (chunk)
  );

  lfbp_bit_acc u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (acc_cmd),
    .sts_o       (acc_sts)
  );

  lfbp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .sts_o       (ost_sts)
  );

  `LFBP_ASSERT(a_accept_no_held, (in_valid_i && !in_stall_o) |-> !ost_sts.held, "request accepted with a byte still held")
  `LFBP_ASSERT(a_idle_drained, ctrl_idle |-> !acc_sts.cnt_ge8, "idle with a complete byte pending")
  `LFBP_ASSERT_NEVER(a_err_no_byte, out_valid_o && out_data_o.status && out_data_o.byte_valid, "rejected request carries a byte")

endmodule

// ----- tb/lsb_first_field_bit_packer_tb.sv -----
// Self-checking testbench for the LSB-first field bit packer.
`timescale 1ns / 1ps

module lsb_first_field_bit_packer_tb;

  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned PHASE_ITEMS    = 48;
  localparam int unsigned U64_LAST_SHIFT = 60;
  // U64 prefix selectors
  localparam int unsigned PFX_ZERO  = 0;
  localparam int unsigned PFX_SMALL = 1;
  localparam int unsigned PFX_MID   = 2;
  localparam int unsigned PFX_WIDE  = 3;

  localparam lfbp_pkg::out_t EMPTY_OK =
    '{out_byte: 8'h00, byte_valid: 1'b0, status: 1'b0, last: 1'b1};
  localparam lfbp_pkg::out_t REJECTED =
    '{out_byte: 8'h00, byte_valid: 1'b0, status: 1'b1, last: 1'b1};

  typedef struct {
    lfbp_pkg::in_t  word;
    bit             typed;
    lfbp_pkg::out_t want;
  } row_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  lfbp_pkg::in_t                  in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  lfbp_pkg::out_t                 out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [lfbp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]                     cfg_data = '0;

  // packer model state
  logic [7:0] pre_bits = '0;
  logic [2:0] pre_cnt = '0;
  logic [6:0] pend_bits = '0;
  logic [2:0] pend_cnt = '0;

  lfbp_pkg::out_t req_words[$];
  lfbp_pkg::out_t exp_words[$];
  row_t           plan[$];
  int             errors = 0;
  bit             tx_calm = 1'b0;
  bit             rx_calm = 1'b0;
  int             hold_asks = 0;

  always #5 clk = ~clk;

  lsb_first_field_bit_packer u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  function automatic logic [63:0] low_ones(input int unsigned n);
    return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
  endfunction

  function automatic void append_bits(input logic [63:0] v, input int unsigned n);
    logic [63:0] acc;
    int unsigned cnt;
    if (n == 0) return;
    acc = {57'd0, pend_bits} | ((v & low_ones(n)) << pend_cnt);
    cnt = pend_cnt + n;
    while (cnt >= 8) begin
      req_words.push_back('{out_byte: acc[7:0], byte_valid: 1'b1, status: 1'b0,
                            last: 1'b0});
      acc = acc >> 8;
      cnt -= 8;
    end
    pend_bits = acc[6:0];
    pend_cnt  = cnt[2:0];
  endfunction

  function automatic void pack_u64(input logic [63:0] v);
    logic [63:0] s;
    int unsigned sh;
    bit done;
    if (v == 0) begin
      append_bits(64'(PFX_ZERO), 2);
    end else if (v < lfbp_pkg::U64_SMALL_LIM) begin
      append_bits(((v - 1) << 2) | PFX_SMALL, 6);
    end else if (v < lfbp_pkg::U64_MID_LIM) begin
      append_bits(((v - lfbp_pkg::U64_SMALL_LIM) << 2) | PFX_MID, 10);
    end else begin
      append_bits(((v & 64'hFFF) << 2) | PFX_WIDE, 14);
      sh = 12;
      done = 1'b0;
      while (!done) begin
        s = v >> sh;
        if (s == 0) begin
          append_bits(64'd0, 1);
          done = 1'b1;
        end else if (sh == U64_LAST_SHIFT) begin
          append_bits(((s & 64'hF) << 1) | 64'd1, 5);
          done = 1'b1;
        end else begin
          append_bits(((s & 64'hFF) << 1) | 64'd1, 9);
          sh += 8;
        end
      end
    end
  endfunction

  // Advance the packer state by one request and leave its words in req_words.
  function automatic void pack_request(input lfbp_pkg::in_t w);
    logic        bad;
    logic [31:0] offs[4];
    logic [4:0]  wids[4];
    logic [31:0] diff;
    bit          found;
    req_words.delete();
    bad = 1'b0;
    case (w.req_type)
      lfbp_pkg::REQ_RAW: begin
        if (w.bit_count > lfbp_pkg::RAW_MAX_BITS) bad = 1'b1;
        else append_bits(w.value, 32'(w.bit_count));
      end
      lfbp_pkg::REQ_PAD: begin
        if (pend_cnt != 0) append_bits(64'd0, 8 - int'(pend_cnt));
      end
      lfbp_pkg::REQ_U32: begin
        offs = '{w.offset_0, w.offset_1, w.offset_2, w.offset_3};
        wids = '{w.width_0, w.width_1, w.width_2, w.width_3};
        found = 1'b0;
        for (int i = 0; i < 4; i++) begin
          diff = w.value[31:0] - offs[i];
          if (!found && ({32'd0, diff} <= low_ones(wids[i]))) begin
            append_bits(({32'd0, diff} << 2) | 64'(i), wids[i] + 2);
            found = 1'b1;
          end
        end
        bad = !found;
      end
      default: pack_u64(w.value);
    endcase
    if (req_words.size() == 0) req_words.push_back('0);
    foreach (req_words[i]) begin
      req_words[i].status = bad;
      req_words[i].last   = (i == req_words.size() - 1);
    end
  endfunction

  function automatic void load_preload(input logic [lfbp_pkg::CFG_IDX_W-1:0] idx,
                                       input logic [7:0] data);
    if (idx == lfbp_pkg::CFG_PRELOAD_BITS) pre_bits = data;
    else if (idx == lfbp_pkg::CFG_PRELOAD_COUNT) pre_cnt = data[2:0];
    pend_cnt  = pre_cnt;
    pend_bits = pre_bits[6:0] & 7'((8'd1 << pre_cnt) - 8'd1);
  endfunction

  function automatic lfbp_pkg::in_t mk_raw(input logic [63:0] v, input logic [5:0] n);
    lfbp_pkg::in_t w;
    w = '0;
    w.req_type  = lfbp_pkg::REQ_RAW;
    w.value     = v;
    w.bit_count = n;
    return w;
  endfunction

  function automatic lfbp_pkg::in_t mk_pad();
    lfbp_pkg::in_t w;
    w = '0;
    w.req_type = lfbp_pkg::REQ_PAD;
    return w;
  endfunction

  function automatic lfbp_pkg::in_t mk_u64(input logic [63:0] v);
    lfbp_pkg::in_t w;
    w = '0;
    w.req_type = lfbp_pkg::REQ_U64;
    w.value    = v;
    return w;
  endfunction

  function automatic lfbp_pkg::in_t mk_u32(input logic [31:0] v,
                                           input logic [31:0] o0, o1, o2, o3,
                                           input logic [4:0] w0, w1, w2, w3);
    lfbp_pkg::in_t w;
    w = '0;
    w.req_type = lfbp_pkg::REQ_U32;
    w.value    = {32'd0, v};
    w.offset_0 = o0;
    w.offset_1 = o1;
    w.offset_2 = o2;
    w.offset_3 = o3;
    w.width_0  = w0;
    w.width_1  = w1;
    w.width_2  = w2;
    w.width_3  = w3;
    return w;
  endfunction

  function automatic lfbp_pkg::in_t random_request();
    lfbp_pkg::in_t w;
    int unsigned   kind;
    int unsigned   sel;
    logic [31:0]   offs[4];
    logic [4:0]    wids[4];
    logic [31:0]   delta;
    kind = $urandom_range(0, 99);
    w = '0;
    w.value     = {$urandom, $urandom};
    w.bit_count = ($urandom_range(0, 9) == 0) ?
                  6'($urandom_range(lfbp_pkg::RAW_MAX_BITS + 1, 63)) :
                  6'($urandom_range(0, lfbp_pkg::RAW_MAX_BITS));
    for (int j = 0; j < 4; j++) begin
      offs[j] = $urandom;
      wids[j] = 5'($urandom_range(0, 31));
    end
    if (kind < 30) begin
      w.req_type = lfbp_pkg::REQ_RAW;
    end else if (kind < 40) begin
      w.req_type = lfbp_pkg::REQ_PAD;
    end else if (kind < 70) begin
      w.req_type = lfbp_pkg::REQ_U32;
      sel = $urandom_range(0, 3);
      // keep earlier distributions narrow so later selectors get hit
      for (int j = 0; j < 4; j++) if (j < sel) wids[j] = 5'($urandom_range(0, 4));
      if ($urandom_range(0, 7) != 0) begin
        delta = $urandom;
        delta = delta & 32'(low_ones(wids[sel]));
        w.value[31:0] = offs[sel] + delta;
      end else begin
        for (int j = 0; j < 4; j++) wids[j] = 5'($urandom_range(0, 3));
      end
    end else begin
      w.req_type = lfbp_pkg::REQ_U64;
      if ($urandom_range(0, 3) == 0) w.value = 64'($urandom_range(0, 300));
      else w.value = w.value >> $urandom_range(0, 63);
    end
    {w.offset_0, w.offset_1, w.offset_2, w.offset_3} = {offs[0], offs[1], offs[2], offs[3]};
    {w.width_0, w.width_1, w.width_2, w.width_3} = {wids[0], wids[1], wids[2], wids[3]};
    return w;
  endfunction

  task automatic send_request(input lfbp_pkg::in_t w, input bit typed,
                              input lfbp_pkg::out_t want);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 17);
    for (int k = 0; k < gap; k++) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = w;
    do @(posedge clk); while (in_stall);
    pack_request(w);
    if (typed) exp_words.push_back(want);
    else foreach (req_words[i]) exp_words.push_back(req_words[i]);
  endtask

  task automatic write_reg(input logic [lfbp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [7:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    load_preload(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Drop valid, wait out every expected word, then let the block go idle.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (exp_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Receiver: random stall before each word unless rx_calm, one long hold on request.
  initial begin : rx_side
    int hold;
    int served;
    served = 0;
    wait (rst_n);
    forever begin
      if (hold_asks != served) begin
        served = hold_asks;
        hold = HOLD_CYCLES;
      end else begin
        hold = rx_calm ? 0 : $urandom_range(0, 17);
      end
      if (hold > 0) begin
        @(negedge clk);
        out_stall = 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : check_out
    lfbp_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_words.size() == 0) begin
        errors++;
        $display("%0t unexpected word: expected none got %h", $time, out_data);
      end else begin
        want = exp_words.pop_front();
        if (out_data.out_byte !== want.out_byte) begin
          errors++;
          $display("%0t out_byte: expected %h got %h", $time, want.out_byte, out_data.out_byte);
        end
        if (out_data.byte_valid !== want.byte_valid) begin
          errors++;
          $display("%0t byte_valid: expected %b got %b", $time, want.byte_valid,
                   out_data.byte_valid);
        end
        if (out_data.status !== want.status) begin
          errors++;
          $display("%0t status: expected %b got %b", $time, want.status, out_data.status);
        end
        if (out_data.last !== want.last) begin
          errors++;
          $display("%0t last: expected %b got %b", $time, want.last, out_data.last);
        end
      end
    end
  end

  initial begin : stimulus
    plan.push_back('{mk_raw('1, 6'd0), 1'b1, EMPTY_OK});
    plan.push_back('{mk_raw('1, 6'd57), 1'b1, REJECTED});
    plan.push_back('{mk_raw('1, 6'd63), 1'b1, REJECTED});
    plan.push_back('{mk_raw(64'hA5, 6'd8), 1'b1,
                     '{out_byte: 8'hA5, byte_valid: 1'b1, status: 1'b0, last: 1'b1}});
    plan.push_back('{mk_pad(), 1'b1, EMPTY_OK});
    plan.push_back('{mk_u32(32'd5, 32'd10, 32'd10, 32'd10, 32'd10, 5'd0, 5'd0, 5'd0, 5'd0),
                     1'b1, REJECTED});
    plan.push_back('{mk_u64(64'd0), 1'b1, EMPTY_OK});
    plan.push_back('{mk_raw('1, 6'd56), 1'b0, '0});
    plan.push_back('{mk_raw(64'd5, 6'd3), 1'b0, '0});
    plan.push_back('{mk_pad(), 1'b0, '0});
    plan.push_back('{mk_u64(64'd1), 1'b0, '0});
    plan.push_back('{mk_u64(64'd16), 1'b0, '0});
    plan.push_back('{mk_u64(64'd17), 1'b0, '0});
    plan.push_back('{mk_u64(64'd272), 1'b0, '0});
    plan.push_back('{mk_u64(64'd273), 1'b0, '0});
    plan.push_back('{mk_u64('1), 1'b0, '0});
    plan.push_back('{mk_u64(64'd1 << 60), 1'b0, '0});
    plan.push_back('{mk_u64(64'h0123_4567_89AB_CDEF), 1'b0, '0});
    plan.push_back('{mk_u32('1, '1, '1, '1, '1, 5'd0, 5'd0, 5'd0, 5'd0), 1'b0, '0});
    plan.push_back('{mk_u32(32'd100, 32'd0, 32'd0, 32'd0, 32'd90, 5'd0, 5'd1, 5'd2, 5'd5),
                     1'b0, '0});
    // difference wraps below zero into a 31-bit distribution
    plan.push_back('{mk_u32(32'd0, 32'h9000_0000, '1, '1, '1, 5'd31, 5'd0, 5'd0, 5'd0),
                     1'b0, '0});
    plan.push_back('{mk_u32('1, 32'd0, 32'd0, 32'd0, 32'd0, 5'd31, 5'd31, 5'd31, 5'd31),
                     1'b1, REJECTED});
    plan.push_back('{mk_u32(32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0,
                            5'd30, 5'd31, 5'd0, 5'd0), 1'b0, '0});
    plan.push_back('{mk_raw('1, 6'd1), 1'b0, '0});
    plan.push_back('{mk_pad(), 1'b0, '0});

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) send_request(plan[i].word, plan[i].typed, plan[i].want);
    settle();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          write_reg(lfbp_pkg::CFG_PRELOAD_BITS, 8'hFF);
          write_reg(lfbp_pkg::CFG_PRELOAD_COUNT, 8'hFF);
        end
        1: begin
          write_reg(lfbp_pkg::CFG_PRELOAD_BITS, 8'($urandom));
          write_reg(lfbp_pkg::CFG_PRELOAD_COUNT, 8'($urandom));
          hold_asks++;
        end
        default: begin
          write_reg(lfbp_pkg::CFG_PRELOAD_BITS, 8'h00);
          write_reg(lfbp_pkg::CFG_PRELOAD_COUNT, 8'h00);
        end
      endcase
      rx_calm = (phase == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // a back-to-back stretch in every phase, and a full one under the long hold
        tx_calm = (phase == 1) || (n >= 20 && n < 32);
        send_request(random_request(), 1'b0, '0);
      end
      settle();
    end

    if (exp_words.size() != 0) begin
      errors++;
      $display("%0t leftover words: expected 0 got %0d", $time, exp_words.size());
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/lfbp_pkg.sv
hw/rtl/lfbp_chunk_unit.sv
hw/rtl/lfbp_bit_acc.sv
hw/rtl/lfbp_out_stage.sv
hw/rtl/lfbp_ctrl.sv
hw/rtl/lsb_first_field_bit_packer.sv
tb/lsb_first_field_bit_packer_tb.sv
